[rtl/woc_pkg.sv]
// woc_pkg: sizes, widths and action codes for the word occurrence counter
// no dependencies; used by rtl/word_occurrence_counter.sv
package woc_pkg;

  localparam int TEXT_CHARS = 256;
  localparam int MAX_WORD   = 16;

  localparam int ADDR_W = $clog2(TEXT_CHARS);
  localparam int FILL_W = $clog2(TEXT_CHARS + 1);
  localparam int QIDX_W = $clog2(MAX_WORD);
  localparam int QLEN_W = $clog2(MAX_WORD + 1);
  localparam int CHAR_W = 8;
  localparam int CNT_W  = 9;
  localparam int ACT_W  = 2;

  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TEXT_CHARS);
  localparam logic [QLEN_W-1:0] QLEN_MAX = QLEN_W'(MAX_WORD);
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  localparam logic [ACT_W-1:0] ACT_TEXT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

endpackage

[rtl/word_occurrence_counter.sv]
// word_occurrence_counter: text store, query buffer and sequential word compare
// depends on rtl/woc_pkg.sv
//
// Text characters (action text) are written into a single-port text store of
// TEXT_CHARS entries, each tagged with its word end mark (tlast); when the store
// is full further characters are dropped and text_full is reported with every
// result until a clear. Query characters collect in a MAX_WORD-entry buffer. A
// query character with tlast set starts a walk over the text store: one stored
// character is read and compared per cycle through the store's one read port,
// so a query end keeps the block busy until every stored character has been
// compared, and then its single result item is offered; a result still
// waiting on the output holds the end of the walk until it is taken. The block
// is not ready during the walk. A query longer than MAX_WORD reports a count
// of zero with query_too_long set. Characters after the last end mark are read
// but never counted.
module word_occurrence_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] action
  input  logic        s_axis_tlast_i,   // word_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [8:0] match_count, [15:9] zero
  output logic [1:0]  m_axis_tuser_o    // [0] text_full, [1] query_too_long
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;

  logic [woc_pkg::CHAR_W:0]      text_mem [woc_pkg::TEXT_CHARS];
  logic [woc_pkg::CHAR_W-1:0]    query_mem [woc_pkg::MAX_WORD];
  logic [woc_pkg::CHAR_W:0]      rd_data_q;

  logic [woc_pkg::FILL_W-1:0]    fill_q;
  logic                          dropped_q;
  logic [woc_pkg::QLEN_W-1:0]    qlen_q;
  logic                          qovf_q;

  logic [woc_pkg::FILL_W-1:0]    ptr_q;
  logic                          rd_vld_q;
  logic [woc_pkg::QLEN_W-1:0]    widx_q;
  logic                          miss_q;
  logic [woc_pkg::CNT_W-1:0]     cnt_q;

  logic                          m_valid_q;
  logic [woc_pkg::CNT_W-1:0]     m_cnt_q;
  logic                          m_full_q;
  logic                          m_long_q;

  logic in_acc;
  logic act_text, act_query, act_clear;
  logic text_wr, query_wr;
  logic issue, walk_done, out_load;
  logic char_ok, miss_d, word_hit;

  assign in_acc = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    act_text  = 1'b0;
    act_query = 1'b0;
    act_clear = 1'b0;
    case (s_axis_tuser_i)
      woc_pkg::ACT_TEXT:  act_text  = 1'b1;
      woc_pkg::ACT_QUERY: act_query = 1'b1;
      woc_pkg::ACT_CLEAR: act_clear = 1'b1;
      default: ;
    endcase
  end

  assign text_wr  = in_acc & act_text & (fill_q < woc_pkg::FILL_MAX);
  assign query_wr = in_acc & act_query & (qlen_q < woc_pkg::QLEN_MAX);

  assign issue     = (state_q == ST_RUN) & (ptr_q < fill_q);
  assign walk_done = (state_q == ST_RUN) & ~issue & ~rd_vld_q;
  assign out_load  = walk_done & (~m_valid_q | m_axis_tready_i);

  // compare of the current stored character against the query position
  always_comb begin
    char_ok = 1'b0;
    if (widx_q < qlen_q) begin
      char_ok = rd_data_q[woc_pkg::CHAR_W-1:0] == query_mem[widx_q[woc_pkg::QIDX_W-1:0]];
    end
  end
  assign miss_d   = miss_q | ~char_ok;
  assign word_hit = ~miss_d & ((widx_q + woc_pkg::QLEN_W'(1)) == qlen_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc & act_query & s_axis_tlast_i) state_d = ST_RUN;
      ST_RUN:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // text store, single port with registered read
  always_ff @(posedge clk_i) begin
    if (text_wr) begin
      text_mem[fill_q[woc_pkg::ADDR_W-1:0]] <= {s_axis_tlast_i, s_axis_tdata_i};
    end
    if (issue) begin
      rd_data_q <= text_mem[ptr_q[woc_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_wr) begin
      query_mem[qlen_q[woc_pkg::QIDX_W-1:0]] <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      dropped_q <= 1'b0;
      qlen_q    <= '0;
      qovf_q    <= 1'b0;
      ptr_q     <= '0;
      rd_vld_q  <= 1'b0;
      widx_q    <= '0;
      miss_q    <= 1'b0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;

      if (text_wr) begin
        fill_q <= fill_q + woc_pkg::FILL_W'(1);
      end else if (in_acc & act_text) begin
        dropped_q <= 1'b1;
      end
      if (in_acc & act_clear) begin
        fill_q    <= '0;
        dropped_q <= 1'b0;
      end

      if (query_wr) begin
        qlen_q <= qlen_q + woc_pkg::QLEN_W'(1);
      end else if (in_acc & act_query) begin
        qovf_q <= 1'b1;
      end

      // start of walk
      if (in_acc & act_query & s_axis_tlast_i) begin
        ptr_q  <= '0;
        widx_q <= '0;
        miss_q <= 1'b0;
        cnt_q  <= '0;
      end

      if (issue) begin
        ptr_q <= ptr_q + woc_pkg::FILL_W'(1);
      end

      if (rd_vld_q) begin
        if (rd_data_q[woc_pkg::CHAR_W]) begin
          if (word_hit && cnt_q != woc_pkg::CNT_MAX) begin
            cnt_q <= cnt_q + woc_pkg::CNT_W'(1);
          end
          widx_q <= '0;
          miss_q <= 1'b0;
        end else begin
          if (widx_q != woc_pkg::QLEN_MAX) begin
            widx_q <= widx_q + woc_pkg::QLEN_W'(1);
          end
          miss_q <= miss_d;
        end
      end

      if (out_load) begin
        m_valid_q <= 1'b1;
        qlen_q    <= '0;
        qovf_q    <= 1'b0;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_cnt_q  <= qovf_q ? '0 : cnt_q;
      m_full_q <= dropped_q;
      m_long_q <= qovf_q;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(16 - woc_pkg::CNT_W){1'b0}}, m_cnt_q};
  assign m_axis_tuser_o  = {m_long_q, m_full_q};

`ifndef SYNTHESIS
  a_no_read_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !rd_vld_q && !issue)
    else $error("text store read while accepting items");

  a_load_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_RUN))
    else $error("result loaded outside a walk");

  a_long_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_long_q |-> m_cnt_q == '0)
    else $error("overlong query reported a nonzero count");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= woc_pkg::FILL_MAX && qlen_q <= woc_pkg::QLEN_MAX)
    else $error("fill or query length out of range");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> ptr_q <= fill_q && widx_q <= woc_pkg::QLEN_MAX)
    else $error("walk pointer out of range");
`endif

endmodule
